// ----- hdl/qnl_pkg.sv -----
// Shared widths, constants and types for the quaternion nlerp block.
package qnl_pkg;

  localparam int CompW     = 16;
  localparam int BlendW    = 15;
  localparam int QShift    = 14;
  localparam int QOne      = 1 << QShift;
  localparam int NumLanes  = 4;
  localparam int ProdW     = 2 * CompW;
  localparam int DotW      = ProdW + 2;
  localparam int RW        = 31;
  localparam int MagW      = RW - 1;
  localparam int SqW       = 2 * MagW;
  localparam int SumW      = SqW + 2;
  localparam int SqrtSteps = SumW / 2;
  localparam int RootW     = 31;
  localparam int QuoW      = 15;
  localparam int DivW      = RootW + 1 + QuoW;
  localparam int RDelay    = SqrtSteps + 1;
  localparam int NormStage = 6 + SqrtSteps;
  localparam int Depth     = NormStage + 1 + QuoW + 1;
  localparam int ZDelay    = Depth - NormStage;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic [SqW-1:0]          sq_t;

  typedef struct packed {
    logic             zero;
    logic [RootW-1:0] root;
  } norm_t;

endpackage

// ----- hdl/qnl_lane.sv -----
// One component lane: dot term, blend, square, then rounding divide by the root.
module qnl_lane (
  input  logic          clk_i,
  input  logic          en_i,
  input  qnl_pkg::comp_t a_i,
  input  qnl_pkg::comp_t b_i,
  input  logic [qnl_pkg::BlendW-1:0] blend_i,
  output qnl_pkg::prod_t prod_o,
  input  logic          neg_i,
  output qnl_pkg::sq_t   sq_o,
  input  qnl_pkg::norm_t norm_i,
  output qnl_pkg::comp_t out_o
);
  import qnl_pkg::*;

  comp_t               a1_q, b1_q, a2_q, b2_q;
  logic [BlendW-1:0]   wb1_q, wb2_q, wb_d, wa;
  prod_t               p1_q;
  logic signed [CompW:0]   bb;
  logic signed [ProdW-1:0] t1_full;
  logic signed [ProdW:0]   t2_full;
  logic signed [RW-1:0]    t1_q, t2_q, r4_q, r5_q;
  logic [MagW-1:0]         m;
  sq_t                     sq5_q;
  logic signed [RW-1:0]    rp_q [RDelay];
  logic [MagW-1:0]         rabs;
  logic [DivW-1:0]         rem_q [QuoW+1];
  logic [RootW-1:0]        den_q [QuoW+1];
  logic [QuoW-1:0]         quo_q [QuoW+1];
  logic                    neg_q [QuoW+1];
  logic                    zero_q [QuoW+1];
  comp_t                   out_q;
  logic [QuoW:0]           qx;

  assign wb_d = (blend_i > BlendW'(QOne)) ? BlendW'(QOne) : blend_i;
  assign wa   = BlendW'(QOne) - wb2_q;
  assign bb   = neg_i ? -{b2_q[CompW-1], b2_q} : {b2_q[CompW-1], b2_q};
  assign t1_full = $signed({1'b0, wa}) * a2_q;
  assign t2_full = $signed({1'b0, wb2_q}) * bb;
  assign m    = r4_q[RW-1] ? MagW'(-r4_q) : MagW'(r4_q);
  assign rabs = rp_q[RDelay-1][RW-1] ? MagW'(-rp_q[RDelay-1]) : MagW'(rp_q[RDelay-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q  <= a_i;
      b1_q  <= b_i;
      wb1_q <= wb_d;
      p1_q  <= a_i * b_i;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      wb2_q <= wb1_q;
      t1_q  <= RW'(t1_full);
      t2_q  <= RW'(t2_full);
      r4_q  <= t1_q + t2_q;
      r5_q  <= r4_q;
      sq5_q <= SqW'(m) * SqW'(m);
      rp_q[0] <= r5_q;
      for (int j = 1; j < RDelay; j++) begin
        rp_q[j] <= rp_q[j-1];
      end
      rem_q[0]  <= DivW'({rabs, QShift'(0), 1'b0}) + DivW'(norm_i.root);
      den_q[0]  <= norm_i.root;
      quo_q[0]  <= '0;
      neg_q[0]  <= rp_q[RDelay-1][RW-1];
      zero_q[0] <= norm_i.zero;
    end
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    localparam int Sh = QuoW - 1 - j;
    logic [DivW-1:0] dsh;
    assign dsh = DivW'({den_q[j], 1'b0}) << Sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j+1]  <= den_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
        if (rem_q[j] >= dsh) begin
          rem_q[j+1] <= rem_q[j] - dsh;
          quo_q[j+1] <= quo_q[j] | (QuoW'(1) << Sh);
        end else begin
          rem_q[j+1] <= rem_q[j];
          quo_q[j+1] <= quo_q[j];
        end
      end
    end
  end

  assign qx = {1'b0, quo_q[QuoW]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[QuoW]) begin
        out_q <= '0;
      end else if (neg_q[QuoW]) begin
        out_q <= comp_t'(-$signed(qx));
      end else begin
        out_q <= comp_t'(qx);
      end
    end
  end

  assign prod_o = p1_q;
  assign sq_o   = sq5_q;
  assign out_o  = out_q;

endmodule

// ----- hdl/qnl_merge.sv -----
// Merges lane terms: dot product sign, sum of squares and pipelined square root.
module qnl_merge (
  input  logic           clk_i,
  input  logic           en_i,
  input  qnl_pkg::prod_t prod_i [qnl_pkg::NumLanes],
  output logic           neg_o,
  input  qnl_pkg::sq_t   sq_i [qnl_pkg::NumLanes],
  output qnl_pkg::norm_t norm_o
);
  import qnl_pkg::*;

  logic signed [DotW-1:0] dot;
  logic [SumW-1:0]        sum;
  logic                   neg_q;
  logic [SumW-1:0]        rem_q [SqrtSteps+1];
  logic [SumW-1:0]        res_q [SqrtSteps+1];
  logic                   zero_q [SqrtSteps+1];

  always_comb begin
    dot = '0;
    sum = '0;
    for (int i = 0; i < NumLanes; i++) begin
      dot = dot + DotW'(prod_i[i]);
      sum = sum + SumW'(sq_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q     <= dot[DotW-1];
      rem_q[0]  <= sum;
      res_q[0]  <= '0;
      zero_q[0] <= (sum == '0);
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int Pos = 2 * (SqrtSteps - 1 - j);
    logic [SumW-1:0] bitv, trial;
    assign bitv  = SumW'(1) << Pos;
    assign trial = res_q[j] + bitv;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[j+1] <= zero_q[j];
        if (rem_q[j] >= trial) begin
          rem_q[j+1] <= rem_q[j] - trial;
          res_q[j+1] <= (res_q[j] >> 1) + bitv;
        end else begin
          rem_q[j+1] <= rem_q[j];
          res_q[j+1] <= res_q[j] >> 1;
        end
      end
    end
  end

  assign neg_o       = neg_q;
  assign norm_o.zero = zero_q[SqrtSteps];
  assign norm_o.root = res_q[SqrtSteps][RootW-1:0];

endmodule

// ----- hdl/quaternion_nlerp.sv -----
// Top level of the quaternion normalized linear interpolation pipeline.
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | a_*_i, b_*_i, blend_i
//   out     | output    | out_valid_o / out_stall_i| out_*_o, zero_length_o
// One word per cycle while the output word is not held by out_stall_i; 31-step square root, 15-step divide.
// The pipeline moves as a whole; it holds only while the output word waits under stall.
// Reset clears the valid bits only.
module quaternion_nlerp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  qnl_pkg::comp_t        a_w_i,
  input  qnl_pkg::comp_t        a_x_i,
  input  qnl_pkg::comp_t        a_y_i,
  input  qnl_pkg::comp_t        a_z_i,
  input  qnl_pkg::comp_t        b_w_i,
  input  qnl_pkg::comp_t        b_x_i,
  input  qnl_pkg::comp_t        b_y_i,
  input  qnl_pkg::comp_t        b_z_i,
  input  logic [qnl_pkg::BlendW-1:0] blend_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output qnl_pkg::comp_t        out_w_o,
  output qnl_pkg::comp_t        out_x_o,
  output qnl_pkg::comp_t        out_y_o,
  output qnl_pkg::comp_t        out_z_o,
  output logic                  zero_length_o
);
  import qnl_pkg::*;

  logic        en;
  logic [Depth-1:0] v_q;
  comp_t       a_in [NumLanes];
  comp_t       b_in [NumLanes];
  comp_t       res  [NumLanes];
  prod_t       prod [NumLanes];
  sq_t         sq   [NumLanes];
  logic        neg;
  norm_t       norm;
  logic        zd_q [ZDelay];

  assign en = !v_q[Depth-1] || !out_stall_i;
  assign in_stall_o = !en;

  assign a_in[0] = a_w_i;
  assign a_in[1] = a_x_i;
  assign a_in[2] = a_y_i;
  assign a_in[3] = a_z_i;
  assign b_in[0] = b_w_i;
  assign b_in[1] = b_x_i;
  assign b_in[2] = b_y_i;
  assign b_in[3] = b_z_i;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    qnl_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .a_i     (a_in[i]),
      .b_i     (b_in[i]),
      .blend_i (blend_i),
      .prod_o  (prod[i]),
      .neg_i   (neg),
      .sq_o    (sq[i]),
      .norm_i  (norm),
      .out_o   (res[i])
    );
  end

  qnl_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prod),
    .neg_o  (neg),
    .sq_i   (sq),
    .norm_o (norm)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zd_q[0] <= norm.zero;
      for (int j = 1; j < ZDelay; j++) begin
        zd_q[j] <= zd_q[j-1];
      end
    end
  end

  assign out_valid_o   = v_q[Depth-1];
  assign out_w_o       = res[0];
  assign out_x_o       = res[1];
  assign out_y_o       = res[2];
  assign out_z_o       = res[3];
  assign zero_length_o = zd_q[ZDelay-1];

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      out_w_o == 0 && out_x_o == 0 && out_y_o == 0 && out_z_o == 0)
    else $error("zero length word with nonzero components");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_w_o <= 16384 && out_w_o >= -16384 && out_x_o <= 16384 && out_x_o >= -16384 &&
      out_y_o <= 16384 && out_y_o >= -16384 && out_z_o <= 16384 && out_z_o >= -16384)
    else $error("normalized component out of range");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall not tied to held output word");

endmodule

// ----- sim/tb_quaternion_nlerp.sv -----
// Self-checking testbench for quaternion_nlerp: directed table plus random words.
module tb_quaternion_nlerp;
  import qnl_pkg::*;

  typedef struct {
    comp_t a [4];
    comp_t b [4];
    logic [BlendW-1:0] blend;
  } pair_t;

  typedef struct {
    comp_t q [4];
    logic  zero;
  } quat_t;

  typedef struct {
    pair_t p;
    logic  known;
    quat_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  comp_t a_w_i = '0, a_x_i = '0, a_y_i = '0, a_z_i = '0;
  comp_t b_w_i = '0, b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic [BlendW-1:0] blend_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  comp_t out_w_o, out_x_o, out_y_o, out_z_o;
  logic zero_length_o;

  quat_t blend_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  localparam int IdleLimit = 20000;

  always #10 clk_i = ~clk_i;

  quaternion_nlerp DUT (.*);

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic quat_t nlerp(pair_t p);
    quat_t o;
    longint dot, w, r [4], bb;
    longint unsigned sum, mag, num, q, m;
    dot = 0;
    sum = 0;
    w = (p.blend > QOne) ? QOne : p.blend;
    for (int i = 0; i < 4; i++) dot += longint'(p.a[i]) * longint'(p.b[i]);
    for (int i = 0; i < 4; i++) begin
      bb = (dot < 0) ? -longint'(p.b[i]) : longint'(p.b[i]);
      r[i] = (QOne - w) * longint'(p.a[i]) + w * bb;
      m = (r[i] < 0) ? -r[i] : r[i];
      sum += m * m;
    end
    o.zero = (sum == 0);
    mag = o.zero ? 1 : int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      num = ((r[i] < 0) ? -r[i] : r[i]) << QShift;
      q = (2 * num + mag) / (2 * mag);
      if (o.zero) o.q[i] = '0;
      else if (r[i] < 0) o.q[i] = (q > 32768) ? comp_t'(-32768) : comp_t'(-longint'(q));
      else o.q[i] = (q > 32767) ? comp_t'(32767) : comp_t'(q);
    end
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic int gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  task automatic send(pair_t p);
    int g;
    g = gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {a_w_i, a_x_i, a_y_i, a_z_i} <= {p.a[0], p.a[1], p.a[2], p.a[3]};
    {b_w_i, b_x_i, b_y_i, b_z_i} <= {p.b[0], p.b[1], p.b[2], p.b[3]};
    blend_i <= p.blend;
    blend_q.push_back(nlerp(p));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic pair_t rand_pair(int mode);
    pair_t p;
    for (int i = 0; i < 4; i++) begin
      p.a[i] = (mode == 0) ? comp_t'($urandom) :
               comp_t'($signed($urandom_range(0, 32768)) - 16384);
      p.b[i] = (mode == 0) ? comp_t'($urandom) :
               comp_t'($signed($urandom_range(0, 32768)) - 16384);
      if (mode == 2) p.b[i] = -p.a[i];
    end
    case ($urandom_range(0, 5))
      0: p.blend = '0;
      1: p.blend = BlendW'(QOne);
      2: p.blend = BlendW'($urandom);
      default: p.blend = BlendW'($urandom_range(0, QOne));
    endcase
    return p;
  endfunction

  // stall on the result side
  initial begin
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (1 + gap()) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat (gap()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (blend_q.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = blend_q.pop_front();
        if (out_w_o !== e.q[0]) report("out_w", out_w_o, e.q[0]);
        if (out_x_o !== e.q[1]) report("out_x", out_x_o, e.q[1]);
        if (out_y_o !== e.q[2]) report("out_y", out_y_o, e.q[2]);
        if (out_z_o !== e.q[3]) report("out_z", out_z_o, e.q[3]);
        if (zero_length_o !== e.zero) report("zero_length", zero_length_o, e.zero);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    pair_t p;
    comp_t ext [4];
    ext = '{16'sh7fff, -16'sh8000, 16'sh4000, -16'sh4000};
    // identity kept, zero input, opposite halves, extremes, blend above one
    rw.p = '{'{16384, 0, 0, 0}, '{16384, 0, 0, 0}, 8192}; rw.known = 1;
    rw.res = '{'{16384, 0, 0, 0}, 0}; rows.push_back(rw);
    rw.p = '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, 8192}; rw.res = '{'{0, 0, 0, 0}, 1};
    rows.push_back(rw);
    rw.p = '{'{16384, 0, 0, 0}, '{0, 0, 0, 0}, 16384}; rows.push_back(rw);
    rw.p = '{'{0, 16384, 0, 0}, '{0, 0, 0, 0}, 0}; rw.res = '{'{0, 16384, 0, 0}, 0};
    rows.push_back(rw);
    rw.p = '{'{0, 0, 0, 0}, '{0, 0, -16384, 0}, 32767}; rw.res = '{'{0, 0, -16384, 0}, 0};
    rows.push_back(rw);
    rw.known = 0;
    rw.p = '{'{16384, 0, 0, 0}, '{-16384, 0, 0, 0}, 8192}; rows.push_back(rw);
    rw.p = '{'{16384, 0, 0, 0}, '{0, 16384, 0, 0}, 8192}; rows.push_back(rw);
    rw.p = '{'{0, 0, 0, 16384}, '{0, 0, 0, -16384}, 16385}; rows.push_back(rw);
    for (int k = 0; k < 4; k++) begin
      rw.p = '{'{ext[k], ext[k], ext[k], ext[k]}, '{ext[3-k], ext[k], ext[3-k], ext[k]},
               (k == 0) ? 15'h7fff : 15'(4096 * k)};
      rows.push_back(rw);
      rw.p = '{'{ext[k], -ext[k], 0, ext[3-k]}, '{-ext[k], ext[k], ext[k], 0}, 15'(1 + k)};
      rows.push_back(rw);
    end
    rw.p = '{'{-32768, -32768, -32768, -32768}, '{32767, 32767, 32767, 32767}, 16384};
    rows.push_back(rw);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send(rows[i].p);
      if (rows[i].known) begin
        blend_q.pop_back();
        blend_q.push_back(rows[i].res);
      end
    end
    for (int n = 0; n < 1800; n++) begin
      p = rand_pair(($urandom_range(0, 19) == 0) ? 2 : $urandom_range(0, 1));
      send(p);
    end
    in_valid_i <= 1'b0;
    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/qnl_pkg.sv
hdl/qnl_lane.sv
hdl/qnl_merge.sv
hdl/quaternion_nlerp.sv
sim/tb_quaternion_nlerp.sv
